// ===== rtl/core/dtre_pkg.sv =====
// Package for the differential trail round expander.
// Holds payload structs, command codes and fixed widths; no dependencies.
package dtre_pkg;

  localparam int PROB_BITS = 32;
  localparam int PROB_W    = PROB_BITS + 1;
  // Largest count is 16 * 31 * 31 = 15376.
  localparam int CNT_W     = 14;
  localparam int PROD_W    = PROB_W + CNT_W;
  localparam int SHIFT_W   = PROD_W - 8;

  localparam logic [PROB_W-1:0] THRESHOLD_RESET = PROB_W'(42950);
  localparam logic [8:0]        TRANS_MAX       = 9'h1FF;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_EXPAND = 1'b1;

  typedef struct packed {
    logic              command;
    logic [3:0]        table_row;
    logic [3:0]        table_col;
    logic [4:0]        table_count;
    logic [15:0]       difference;
    logic [PROB_W-1:0] path_prob;
  } dtre_in_t;

  typedef struct packed {
    logic [3:0]        round_diff;
    logic [8:0]        trans_count;
    logic [PROB_W-1:0] next_prob;
    logic [15:0]       next_difference;
    logic              kept;
    logic              last;
  } dtre_out_t;

endpackage

// ===== rtl/core/diff_trail_round_expander_core.sv =====
// Top level of the differential trail round expander.
// A 256-entry distribution table in one single-port memory; uses dtre_pkg.
// A load transfer writes the table in its accept cycle.
// An expand transfer reads row x3 (16 reads) and then 256 pair entries, one
// memory read per cycle; the sixteen results pass the read, count, product and
// output registers, and in_ready returns once the datapath has drained.
// The single memory port sets this read rate; output stalls pause the reads.
// rst_n clears control and sets the threshold to 42950; the table is undefined.
module diff_trail_round_expander_core
  import dtre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtre_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dtre_out_t         out_data,
  input  logic              cfg_we,
  input  logic [PROB_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_PAIR,
    S_DRAIN
  } state_t;

  state_t            state_r;
  logic [PROB_W-1:0] thresh_r;

  // Latched expand item.
  logic [3:0]        x0_r, x1_r, x2_r, x3_r;
  logic [PROB_W-1:0] prob_r;

  // Read issue counters.
  logic [3:0]        m_r;
  logic [3:0]        d_r;

  // Table memory and its read stage.
  logic [4:0]        tbl_mem [256];
  logic [4:0]        rdata_r;
  logic              rv_r;
  logic              rkind_r;
  logic [3:0]        rm_r;
  logic [3:0]        rd_r;
  logic              rlast_r;

  // Row buffer for T[x3][*] and the accumulator.
  logic [4:0]        row_r [16];
  logic [CNT_W-1:0]  acc_r;
  logic [CNT_W-1:0]  acc_nxt;

  logic              cv_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [3:0]        cd_r;

  logic              mv_r;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  mcnt_r;
  logic [3:0]        md_r;

  logic              out_valid_r;
  dtre_out_t         out_r;
  dtre_out_t         out_nxt;

  logic              adv;
  logic              issue;
  logic              tbl_we;
  logic [7:0]        mem_addr;
  logic [SHIFT_W-1:0] shifted;
  logic [PROB_W-1:0] np_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The whole datapath holds while a finished count waits on a full output.
  assign adv    = !(mv_r && out_valid_r && !out_ready);
  assign issue  = adv && ((state_r == S_ROW) || (state_r == S_PAIR));
  assign tbl_we = in_valid && in_ready && (in_data.command == CMD_LOAD);

  always_comb begin
    if (state_r == S_IDLE) begin
      mem_addr = {in_data.table_row, in_data.table_col};
    end else if (state_r == S_ROW) begin
      mem_addr = {x3_r, m_r};
    end else begin
      mem_addr = {x2_r ^ m_r, d_r};
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[mem_addr] <= in_data.table_count;
    end
    if (issue) begin
      rdata_r <= tbl_mem[mem_addr];
    end
  end

  always_comb begin
    acc_nxt = ((rm_r == 4'd0) ? '0 : acc_r)
            + CNT_W'(row_r[rm_r]) * CNT_W'(rdata_r);
  end

  always_comb begin
    shifted = prod_r[PROD_W-1:8];
    if (shifted[SHIFT_W-1:PROB_W] != '0) begin
      np_sat = '1;
    end else begin
      np_sat = shifted[PROB_W-1:0];
    end
    out_nxt.round_diff      = md_r;
    out_nxt.trans_count     = (mcnt_r > CNT_W'(TRANS_MAX)) ? TRANS_MAX : mcnt_r[8:0];
    out_nxt.next_prob       = np_sat;
    out_nxt.next_difference = {x1_r, x2_r, x3_r, x0_r ^ md_r};
    out_nxt.kept            = (mcnt_r != '0) && (np_sat >= thresh_r);
    out_nxt.last            = (md_r == 4'hF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thresh_r    <= THRESHOLD_RESET;
      m_r         <= '0;
      d_r         <= '0;
      rv_r        <= 1'b0;
      cv_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_data;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid && in_data.command == CMD_EXPAND) begin
            x0_r    <= in_data.difference[15:12];
            x1_r    <= in_data.difference[11:8];
            x2_r    <= in_data.difference[7:4];
            x3_r    <= in_data.difference[3:0];
            prob_r  <= in_data.path_prob;
            m_r     <= '0;
            d_r     <= '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          if (issue) begin
            m_r <= m_r + 4'd1;
            if (m_r == 4'hF) begin
              state_r <= S_PAIR;
            end
          end
        end
        S_PAIR: begin
          if (issue) begin
            m_r <= m_r + 4'd1;
            if (m_r == 4'hF) begin
              d_r <= d_r + 4'd1;
              if (d_r == 4'hF) begin
                state_r <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (!rv_r && !cv_r && !mv_r) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (adv) begin
        // Read tag stage, aligned with rdata_r.
        rv_r    <= issue;
        rkind_r <= (state_r == S_PAIR);
        rm_r    <= m_r;
        rd_r    <= d_r;
        rlast_r <= (state_r == S_PAIR) && (m_r == 4'hF);

        // Row fill and accumulation.
        if (rv_r && !rkind_r) begin
          row_r[rm_r] <= rdata_r;
        end
        if (rv_r && rkind_r) begin
          acc_r <= acc_nxt;
        end
        cv_r  <= rv_r && rkind_r && rlast_r;
        cnt_r <= acc_nxt;
        cd_r  <= rd_r;

        // Probability product.
        mv_r   <= cv_r;
        prod_r <= PROD_W'(prob_r) * PROD_W'(cnt_r);
        mcnt_r <= cnt_r;
        md_r   <= cd_r;
      end

      if (mv_r && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_r       <= out_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A table write only happens while no read is in flight.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (!issue && !rv_r))
    else $error("table write overlaps a read");

  // Accepting an item requires an empty datapath.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rv_r && !cv_r && !mv_r))
    else $error("idle with work in the datapath");

  // A stalled product holds until the output register takes it.
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_r && out_valid_r && !out_ready) |=> (mv_r && $stable(prod_r) && $stable(md_r)))
    else $error("pending product lost during stall");

  // The last flag marks only the round difference fifteen.
  a_last_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (out_r.round_diff == 4'hF))
    else $error("last flag on wrong round difference");

  // A count is completed only after a pair read with the final m.
  a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cv_r) |-> $past(rv_r && rkind_r && rlast_r))
    else $error("count completed without final pair read");

endmodule
